// ===== sv/vwd_pkg.sv =====
// shared types and constants for the vertex weld dedup block
`default_nettype none

package vwd_pkg;

  localparam int COORD_W   = 18;
  localparam int TOL_W     = 12;
  localparam int TOLSQ_W   = 2 * TOL_W;
  localparam int IDX_W     = 10;
  localparam int AD_W      = COORD_W;
  localparam int SQ_W      = 2 * AD_W;
  localparam int SUM_W     = SQ_W + 2;
  localparam int FRAC_BITS = 12;

  // round(0.01 * 2^FRAC_BITS), saturated to the register range
  localparam int TOL_RAW   = ((1 << FRAC_BITS) + 50) / 100;
  localparam int TOL_MAX   = (1 << TOL_W) - 1;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'((TOL_RAW > TOL_MAX) ? TOL_MAX : TOL_RAW);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  typedef struct packed {
    logic issue;
    logic flush;
  } dist_ctl_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } dist_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== sv/vwd_if.sv =====
// request channel interfaces of the vertex weld dedup block
`default_nettype none

interface vwd_in_if;
  logic             valid;
  logic             ready;
  vwd_pkg::coord_t  coord_x;
  vwd_pkg::coord_t  coord_y;
  vwd_pkg::coord_t  coord_z;
  logic             first_of_list;

  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  output first_of_list, input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                  input first_of_list, output ready);
endinterface

interface vwd_out_if;
  logic                        valid;
  logic                        ready;
  logic [vwd_pkg::IDX_W-1:0]   vertex_index;
  logic                        is_new;
  logic                        table_full;

  modport source (output valid, output vertex_index, output is_new, output table_full,
                  input ready);
  modport sink   (input valid, input vertex_index, input is_new, input table_full,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/vertex_weld_dedup.sv =====
// top level of the vertex weld dedup block
`default_nettype none

// Welds incoming 3D vertices (signed Q5.12) against a table of unique vertices.
// Each request is searched against the stored vertices from index 0 upward; the
// first one whose squared distance is strictly below tolerance squared gives the
// result index. Without a match the vertex is appended and its new index is
// returned with is_new set; with a full table table_full is set, index 0.
// first_of_list empties the table before the vertex is handled. One request is
// handled at a time. The search is run by the single distance unit that compares
// one stored vertex per cycle behind a four-stage pipeline (memory read,
// difference, square, sum and compare). The next request is taken in the cycle
// after the result leaves. The tolerance register is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while no request is in
// work, and the block itself does not enforce this.
module vertex_weld_dedup #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [vwd_pkg::TOL_W-1:0] cfg_wr_data,
  vwd_in_if.sink                         in_req,
  vwd_out_if.source                      out_req
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = (AW > vwd_pkg::IDX_W) ? AW : vwd_pkg::IDX_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  vwd_pkg::state_t               state_r, state_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [CW-1:0]                 issue_cnt_r, issue_cnt_nxt;
  logic [CW-1:0]                 ret_cnt_r, ret_cnt_nxt;
  logic [vwd_pkg::TOL_W-1:0]     tol_r;
  logic [vwd_pkg::TOLSQ_W-1:0]   tol_sq_r, tol_sq_nxt;
  vwd_pkg::vertex_t              ref_r, ref_nxt;
  logic [vwd_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic                          is_new_r, is_new_nxt;
  logic                          full_r, full_nxt;

  vwd_pkg::dist_ctl_t            dctl;
  vwd_pkg::dist_res_t            dres;
  vwd_pkg::vertex_t              st_rdata;
  logic                          mem_wr_en;
  logic [XW-1:0]                 ret_ext;
  logic [XW-1:0]                 cnt_ext;

  // widen the table index so it can be cut to the result field at any depth
  assign ret_ext = XW'(ret_cnt_r[AW-1:0]);
  assign cnt_ext = XW'(count_r[AW-1:0]);

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= vwd_pkg::TOL_RESET;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    issue_cnt_nxt = issue_cnt_r;
    ret_cnt_nxt   = ret_cnt_r;
    tol_sq_nxt    = tol_sq_r;
    ref_nxt       = ref_r;
    idx_nxt       = idx_r;
    is_new_nxt    = is_new_r;
    full_nxt      = full_r;
    dctl          = '0;
    mem_wr_en     = 1'b0;
    in_req.ready  = 1'b0;
    out_req.valid = 1'b0;

    case (state_r)
      vwd_pkg::ST_IDLE: begin
        in_req.ready = 1'b1;
        if (in_req.valid) begin
          // latch the vertex, square the tolerance once per request
          ref_nxt.x     = in_req.coord_x;
          ref_nxt.y     = in_req.coord_y;
          ref_nxt.z     = in_req.coord_z;
          tol_sq_nxt    = {{vwd_pkg::TOL_W{1'b0}}, tol_r} * {{vwd_pkg::TOL_W{1'b0}}, tol_r};
          issue_cnt_nxt = '0;
          ret_cnt_nxt   = '0;
          if (in_req.first_of_list) begin
            count_nxt = '0;
          end
          state_nxt = vwd_pkg::ST_SEARCH;
        end
      end

      vwd_pkg::ST_SEARCH: begin
        if (ret_cnt_r == count_r) begin
          // every stored vertex compared without a match
          if (count_r == DEPTH_C) begin
            idx_nxt    = '0;
            is_new_nxt = 1'b0;
            full_nxt   = 1'b1;
          end else begin
            mem_wr_en  = 1'b1;
            idx_nxt    = cnt_ext[vwd_pkg::IDX_W-1:0];
            is_new_nxt = 1'b1;
            full_nxt   = 1'b0;
            count_nxt  = count_r + 1'b1;
          end
          state_nxt = vwd_pkg::ST_DONE;
        end else if (dres.valid && dres.hit) begin
          // first match in table order; drop what is still in the pipe
          dctl.flush = 1'b1;
          idx_nxt    = ret_ext[vwd_pkg::IDX_W-1:0];
          is_new_nxt = 1'b0;
          full_nxt   = 1'b0;
          state_nxt  = vwd_pkg::ST_DONE;
        end else begin
          if (dres.valid) begin
            ret_cnt_nxt = ret_cnt_r + 1'b1;
          end
          if (issue_cnt_r < count_r) begin
            dctl.issue    = 1'b1;
            issue_cnt_nxt = issue_cnt_r + 1'b1;
          end
        end
      end

      vwd_pkg::ST_DONE: begin
        out_req.valid = 1'b1;
        if (out_req.ready) begin
          state_nxt = vwd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = vwd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vwd_pkg::ST_IDLE;
      count_r     <= '0;
      issue_cnt_r <= '0;
      ret_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      ret_cnt_r   <= ret_cnt_nxt;
    end
  end

  // request payload and result registers
  always_ff @(posedge clk) begin
    tol_sq_r <= tol_sq_nxt;
    ref_r    <= ref_nxt;
    idx_r    <= idx_nxt;
    is_new_r <= is_new_nxt;
    full_r   <= full_nxt;
  end

  assign out_req.vertex_index = idx_r;
  assign out_req.is_new       = is_new_r;
  assign out_req.table_full   = full_r;

  vwd_store #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (ref_r),
    .rd_en   (dctl.issue),
    .rd_addr (issue_cnt_r[AW-1:0]),
    .rd_data (st_rdata)
  );

  vwd_dist u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (dctl),
    .ref_v  (ref_r),
    .tol_sq (tol_sq_r),
    .st_v   (st_rdata),
    .res    (dres)
  );

`ifndef SYNTHESIS
  // table fill never runs past the memory
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("unique count exceeds table depth");

  // a result is never both appended and rejected
  a_new_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_req.valid |-> !(out_req.is_new && out_req.table_full))
    else $error("is_new and table_full both set");

  // a rejected vertex only happens with the table full
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_req.valid && out_req.table_full) |-> (count_r == DEPTH_C))
    else $error("table_full reported with room in the table");

  // an accepted request always starts a search
  a_accept_search: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> (state_r == vwd_pkg::ST_SEARCH))
    else $error("accepted request did not start a search");
`endif

endmodule

`default_nettype wire

// ===== sv/vwd_store.sv =====
// unique vertex memory, one write and one registered read port
`default_nettype none

module vwd_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire vwd_pkg::vertex_t wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output vwd_pkg::vertex_t      rd_data
);

  vwd_pkg::vertex_t mem [DEPTH];
  vwd_pkg::vertex_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== sv/vwd_dist.sv =====
// pipelined squared distance and tolerance compare, one stored vertex per cycle
`default_nettype none

module vwd_dist (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire vwd_pkg::dist_ctl_t          ctl,
  input  wire vwd_pkg::vertex_t            ref_v,
  input  wire logic [vwd_pkg::TOLSQ_W-1:0] tol_sq,
  input  wire vwd_pkg::vertex_t            st_v,
  output vwd_pkg::dist_res_t               res
);

  logic [3:0]                 v_r;
  logic [3:0]                 v_nxt;
  logic [vwd_pkg::AD_W-1:0]   ad_r  [3];
  logic [vwd_pkg::AD_W-1:0]   ad_nxt [3];
  logic [vwd_pkg::SQ_W-1:0]   sq_r  [3];
  logic [vwd_pkg::SUM_W-1:0]  sum;
  logic                       hit_r;
  logic                       hit_nxt;

  function automatic logic [vwd_pkg::AD_W-1:0] abs_diff(vwd_pkg::coord_t a,
                                                         vwd_pkg::coord_t b);
    logic signed [vwd_pkg::COORD_W:0] d;
    logic signed [vwd_pkg::COORD_W:0] m;
    d = {a[vwd_pkg::COORD_W-1], a} - {b[vwd_pkg::COORD_W-1], b};
    m = d[vwd_pkg::COORD_W] ? -d : d;
    return m[vwd_pkg::AD_W-1:0];
  endfunction

  // valid bits: stage 0 lines up with the memory read data
  always_comb begin
    v_nxt = {v_r[2:0], ctl.issue};
    if (ctl.flush) begin
      v_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_comb begin
    ad_nxt[0] = abs_diff(ref_v.x, st_v.x);
    ad_nxt[1] = abs_diff(ref_v.y, st_v.y);
    ad_nxt[2] = abs_diff(ref_v.z, st_v.z);
  end

  assign sum = {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};
  assign hit_nxt = sum < {{(vwd_pkg::SUM_W - vwd_pkg::TOLSQ_W){1'b0}}, tol_sq};

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ad_r[i] <= ad_nxt[i];
      sq_r[i] <= ad_r[i] * ad_r[i];
    end
    hit_r <= hit_nxt;
  end

  assign res.valid = v_r[3];
  assign res.hit   = hit_r;

endmodule

`default_nettype wire
